/* src/i2cebm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cebm_pkg: shared types and constants of the I2C EEPROM byte master
// Bus phase codes, command codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cebm_pkg;

    // Default width of the half-phase tick counter
    localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

    // Configuration register widths and reset values
    localparam int HALF_PERIOD_W = 16;
    localparam int DEV_ADDR_W    = 7;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd60;
    localparam logic [DEV_ADDR_W-1:0]    DEV_ADDR_RESET    = 7'd80;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_DEV_ADDR    = 1'b1;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Byte stage within a transfer
    localparam logic [1:0] STAGE_DEV  = 2'd0;
    localparam logic [1:0] STAGE_ADDR = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;
    localparam logic [1:0] STAGE_RECV = 2'd3;

    // Bus phases: start, write bit, ack slot, read bit, nack slot, stop
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST_A = 4'd1,
        PH_ST_B = 4'd2,
        PH_ST_C = 4'd3,
        PH_WB_H = 4'd4,
        PH_WB_L = 4'd5,
        PH_AK_H = 4'd6,
        PH_AK_L = 4'd7,
        PH_RB_H = 4'd8,
        PH_RB_L = 4'd9,
        PH_NK_H = 4'd10,
        PH_NK_L = 4'd11,
        PH_SP_A = 4'd12,
        PH_SP_B = 4'd13,
        PH_SP_C = 4'd14
    } phase_t;

    // One result item per tick
    typedef struct packed {
        logic       ack_error;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl;
    } result_t;

    localparam int RESULT_W = 13;
    localparam int M_TDATA_W = 16;

endpackage

`default_nettype wire

/* src/i2cebm_core.sv */
// ----------------------------------------------------------------------------
// i2cebm_core: bus sequencer of the I2C EEPROM byte master
// Holds the transfer state and advances it by one tick per step, producing
// the line levels and status for that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cebm_core #(
    parameter int TICK_COUNT_WIDTH = i2cebm_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 step,
    input  wire logic [1:0]                           cmd,
    input  wire logic [7:0]                           mem_address,
    input  wire logic [7:0]                           write_data,
    input  wire logic                                 sda_in,
    input  wire logic [i2cebm_pkg::HALF_PERIOD_W-1:0] half_period,
    input  wire logic [i2cebm_pkg::DEV_ADDR_W-1:0]    device_address,
    output i2cebm_pkg::result_t                       result
);

    localparam int HPW   = i2cebm_pkg::HALF_PERIOD_W;
    localparam int CMP_W = (TICK_COUNT_WIDTH > HPW) ? TICK_COUNT_WIDTH : HPW;

    i2cebm_pkg::phase_t          phase_reg, phase_next;
    logic [3:0]                  bit_count_reg, bit_count_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [7:0]                  saved_address_reg, saved_address_next;
    logic [7:0]                  saved_data_reg, saved_data_next;
    logic                        is_read_reg, is_read_next;
    logic                        missing_ack_reg, missing_ack_next;
    logic [7:0]                  received_byte_reg, received_byte_next;
    logic [1:0]                  stage_reg, stage_next;

    // Half period with zero treated as one, its last tick and sample point
    logic [HPW-1:0] hp;
    logic [HPW-1:0] hp_last;
    logic [HPW-1:0] hp_mid;

    assign hp      = (half_period == '0) ? HPW'(1) : half_period;
    assign hp_last = hp - HPW'(1);
    assign hp_mid  = hp >> 1;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2cebm_pkg::PH_IDLE;
            bit_count_reg     <= '0;
            tick_count_reg    <= '0;
            shift_reg         <= '0;
            saved_address_reg <= '0;
            saved_data_reg    <= '0;
            is_read_reg       <= 1'b0;
            missing_ack_reg   <= 1'b0;
            received_byte_reg <= '0;
            stage_reg         <= i2cebm_pkg::STAGE_DEV;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            tick_count_reg    <= tick_count_next;
            shift_reg         <= shift_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            is_read_reg       <= is_read_next;
            missing_ack_reg   <= missing_ack_next;
            received_byte_reg <= received_byte_next;
            stage_reg         <= stage_next;
        end
    end

    // One tick of the sequencer
    always_comb
    begin
        logic                  scl_o;
        logic                  sda_o;
        logic                  busy;
        logic                  done;
        logic                  seg_end;
        logic [3:0]            bc_inc;
        i2cebm_pkg::phase_t    cur;

        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        tick_count_next    = tick_count_reg;
        shift_next         = shift_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        is_read_next       = is_read_reg;
        missing_ack_next   = missing_ack_reg;
        received_byte_next = received_byte_reg;
        stage_next         = stage_reg;
        scl_o   = 1'b1;
        sda_o   = 1'b1;
        busy    = 1'b0;
        done    = 1'b0;
        seg_end = 1'b0;
        bc_inc  = '0;

        // Command start, taken only while idle
        if (phase_reg == i2cebm_pkg::PH_IDLE &&
            (cmd == i2cebm_pkg::CMD_WRITE || cmd == i2cebm_pkg::CMD_READ))
        begin
            saved_address_next = mem_address;
            saved_data_next    = write_data;
            is_read_next       = (cmd == i2cebm_pkg::CMD_READ);
            missing_ack_next   = 1'b0;
            stage_next         = i2cebm_pkg::STAGE_DEV;
            bit_count_next     = '0;
            tick_count_next    = '0;
            phase_next         = i2cebm_pkg::PH_ST_A;
        end
        cur = phase_next;

        if (cur != i2cebm_pkg::PH_IDLE)
        begin
            busy = 1'b1;

            // Line levels and sampling at mid high phase
            case (cur)
                i2cebm_pkg::PH_ST_A: begin scl_o = 1'b1; sda_o = 1'b1; end
                i2cebm_pkg::PH_ST_B: begin scl_o = 1'b1; sda_o = 1'b0; end
                i2cebm_pkg::PH_ST_C: begin scl_o = 1'b0; sda_o = 1'b0; end
                i2cebm_pkg::PH_WB_H: begin scl_o = 1'b1; sda_o = shift_next[7]; end
                i2cebm_pkg::PH_WB_L: begin scl_o = 1'b0; sda_o = shift_next[7]; end
                i2cebm_pkg::PH_AK_H:
                begin
                    scl_o = 1'b1;
                    sda_o = 1'b1;
                    if (CMP_W'(tick_count_next) == CMP_W'(hp_mid))
                        missing_ack_next = missing_ack_next | sda_in;
                end
                i2cebm_pkg::PH_RB_H:
                begin
                    scl_o = 1'b1;
                    sda_o = 1'b1;
                    if (CMP_W'(tick_count_next) == CMP_W'(hp_mid))
                        shift_next = {shift_next[6:0], sda_in};
                end
                i2cebm_pkg::PH_NK_H: begin scl_o = 1'b1; sda_o = 1'b1; end
                i2cebm_pkg::PH_SP_A: begin scl_o = 1'b0; sda_o = 1'b0; end
                i2cebm_pkg::PH_SP_B: begin scl_o = 1'b1; sda_o = 1'b0; end
                i2cebm_pkg::PH_SP_C: begin scl_o = 1'b1; sda_o = 1'b1; end
                default:             begin scl_o = 1'b0; sda_o = 1'b1; end
            endcase

            // End of the half phase
            seg_end = (CMP_W'(tick_count_next) >= CMP_W'(hp_last)) ||
                      (tick_count_next == {TICK_COUNT_WIDTH{1'b1}});

            if (!seg_end)
            begin
                tick_count_next = tick_count_next + TICK_COUNT_WIDTH'(1);
            end
            else
            begin
                tick_count_next = '0;
                bc_inc = bit_count_next + 4'd1;
                case (cur)
                    i2cebm_pkg::PH_ST_A: phase_next = i2cebm_pkg::PH_ST_B;
                    i2cebm_pkg::PH_ST_B: phase_next = i2cebm_pkg::PH_ST_C;
                    i2cebm_pkg::PH_ST_C:
                    begin
                        shift_next = {device_address,
                                      (stage_next == i2cebm_pkg::STAGE_DATA)};
                        bit_count_next = '0;
                        phase_next = i2cebm_pkg::PH_WB_H;
                    end
                    i2cebm_pkg::PH_WB_H: phase_next = i2cebm_pkg::PH_WB_L;
                    i2cebm_pkg::PH_WB_L:
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bc_inc >= 4'd8)
                        begin
                            bit_count_next = '0;
                            phase_next = i2cebm_pkg::PH_AK_H;
                        end
                        else
                        begin
                            bit_count_next = bc_inc;
                            phase_next = i2cebm_pkg::PH_WB_H;
                        end
                    end
                    i2cebm_pkg::PH_AK_H: phase_next = i2cebm_pkg::PH_AK_L;
                    i2cebm_pkg::PH_AK_L:
                    begin
                        if (stage_next == i2cebm_pkg::STAGE_DEV)
                        begin
                            stage_next = i2cebm_pkg::STAGE_ADDR;
                            shift_next = saved_address_next;
                            bit_count_next = '0;
                            phase_next = i2cebm_pkg::PH_WB_H;
                        end
                        else if (stage_next == i2cebm_pkg::STAGE_ADDR)
                        begin
                            stage_next = i2cebm_pkg::STAGE_DATA;
                            if (is_read_next)
                            begin
                                // repeated start for the device-read byte
                                phase_next = i2cebm_pkg::PH_ST_A;
                            end
                            else
                            begin
                                shift_next = saved_data_next;
                                bit_count_next = '0;
                                phase_next = i2cebm_pkg::PH_WB_H;
                            end
                        end
                        else if (stage_next == i2cebm_pkg::STAGE_DATA && is_read_next)
                        begin
                            stage_next = i2cebm_pkg::STAGE_RECV;
                            shift_next = '0;
                            bit_count_next = '0;
                            phase_next = i2cebm_pkg::PH_RB_H;
                        end
                        else
                        begin
                            phase_next = i2cebm_pkg::PH_SP_A;
                        end
                    end
                    i2cebm_pkg::PH_RB_H: phase_next = i2cebm_pkg::PH_RB_L;
                    i2cebm_pkg::PH_RB_L:
                    begin
                        if (bc_inc >= 4'd8)
                        begin
                            bit_count_next = '0;
                            received_byte_next = shift_next;
                            phase_next = i2cebm_pkg::PH_NK_H;
                        end
                        else
                        begin
                            bit_count_next = bc_inc;
                            phase_next = i2cebm_pkg::PH_RB_H;
                        end
                    end
                    i2cebm_pkg::PH_NK_H: phase_next = i2cebm_pkg::PH_NK_L;
                    i2cebm_pkg::PH_NK_L: phase_next = i2cebm_pkg::PH_SP_A;
                    i2cebm_pkg::PH_SP_A: phase_next = i2cebm_pkg::PH_SP_B;
                    i2cebm_pkg::PH_SP_B: phase_next = i2cebm_pkg::PH_SP_C;
                    i2cebm_pkg::PH_SP_C:
                    begin
                        done = 1'b1;
                        phase_next = i2cebm_pkg::PH_IDLE;
                        stage_next = i2cebm_pkg::STAGE_DEV;
                    end
                    default:
                    begin
                        phase_next = i2cebm_pkg::PH_IDLE;
                        stage_next = i2cebm_pkg::STAGE_DEV;
                    end
                endcase
            end
        end

        result.scl       = scl_o;
        result.sda_out   = sda_o;
        result.busy_res  = busy;
        result.done_res  = done;
        result.read_data = received_byte_next;
        result.ack_error = missing_ack_next;
    end

endmodule

`default_nettype wire

/* src/i2cebm_out_stage.sv */
// ----------------------------------------------------------------------------
// i2cebm_out_stage: result register of the I2C EEPROM byte master
// Holds one result transfer on the master side until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cebm_out_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire i2cebm_pkg::result_t                result,
    output logic                                    ready,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // scl, sda_out, busy_res, done_res, read_data[7:0], ack_error, zero pad
    output logic [i2cebm_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic                valid_reg, valid_next;
    i2cebm_pkg::result_t data_reg;

    // Free when empty or when the held transfer leaves this cycle
    assign ready = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(i2cebm_pkg::M_TDATA_W - i2cebm_pkg::RESULT_W){1'b0}}, data_reg};

endmodule

`default_nettype wire

/* src/i2c_eeprom_byte_master_unit.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_unit: I2C master for byte write and random read
// Each input transfer is one timing tick; each tick yields one result with
// the SCL and SDA drive levels, busy and done flags, read byte and ACK error.
//
// Usage:
//   Slave side takes a tick with a command (tuser) and the address, data and
//   sampled SDA level (tdata). Command 1 starts a byte write, 2 a byte read;
//   commands are ignored while a transfer runs. Master side returns one
//   result transfer per tick, in order.
//   An input transfer is held in the input register, then the sequencer step
//   loads its result into the result register, which raises tvalid.
//   Throughput is one tick per cycle while the receiver does not stall; the
//   sequencer state machine advances once per tick.
//   When the receiver stalls, the result register holds and the input
//   register fills, then tready drops until the receiver takes the result.
//   Reset clears the bus state to idle (both lines released), empties both
//   registers and loads half_period = 60 and device_address = 80.
//   Configuration writes land on the rising edge with cfg_wen high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_master_unit #(
    parameter int TICK_COUNT_WIDTH = i2cebm_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mem_address[7:0], write_data[15:8], sda_in[16], zero pad
    input  wire logic [23:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // scl, sda_out, busy_res, done_res, read_data[7:0], ack_error, zero pad
    output logic [15:0]      m_tdata
);

    logic [i2cebm_pkg::HALF_PERIOD_W-1:0] half_period_reg;
    logic [i2cebm_pkg::DEV_ADDR_W-1:0]    device_address_reg;

    logic       in_valid_reg, in_valid_next;
    logic [1:0] cmd_reg;
    logic [7:0] mem_address_reg;
    logic [7:0] write_data_reg;
    logic       sda_in_reg;

    logic                out_ready;
    logic                advance;
    logic                in_take;
    i2cebm_pkg::result_t result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg    <= i2cebm_pkg::HALF_PERIOD_RESET;
            device_address_reg <= i2cebm_pkg::DEV_ADDR_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                i2cebm_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_wdata;
                i2cebm_pkg::CFG_DEV_ADDR:
                    device_address_reg <= cfg_wdata[i2cebm_pkg::DEV_ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register handshake
    assign advance  = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg         <= s_tuser;
            mem_address_reg <= s_tdata[7:0];
            write_data_reg  <= s_tdata[15:8];
            sda_in_reg      <= s_tdata[16];
        end
    end

    // Bus sequencer
    i2cebm_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .cmd            (cmd_reg),
        .mem_address    (mem_address_reg),
        .write_data     (write_data_reg),
        .sda_in         (sda_in_reg),
        .half_period    (half_period_reg),
        .device_address (device_address_reg),
        .result         (result)
    );

    // Result register
    i2cebm_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
